FILE: rtl/tcrr_pkg.sv
// Shared types, constants and codes of the text console row ring.
`default_nettype none

package tcrr_pkg;

  localparam int ROWS_DEF    = 25;
  localparam int COLUMNS_DEF = 80;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_ACK   = 2'd3
  } cmd_code_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_WRITE,
    ST_READ,
    ST_ZERO_SETUP,
    ST_ZERO,
    ST_CURSOR,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
    logic [4:0] screen_row;
    logic [6:0] screen_col;
  } request_t;

  typedef struct packed {
    logic [7:0]  cell_char;
    logic [11:0] cursor_offset;
    logic        redraw_needed;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic load_addr;
    logic write_cell;
    logic zero_setup;
    logic zero_step;
    logic clear_step;
    logic read_cell;
    logic calc_vis;
    logic emit;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_code_t req_cmd;
    logic      wrap_full;
    logic      zero_last;
    logic      clear_last;
    logic      clear_reply;
  } ctl_stat_t;

endpackage

`default_nettype wire

FILE: rtl/tcrr_ctrl.sv
// Controller state machine that sequences each command through the datapath.
`default_nettype none

module tcrr_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire tcrr_pkg::cmd_code_t  command,
  input  wire tcrr_pkg::ctl_stat_t  stat,
  output tcrr_pkg::ctl_cmd_t        ctl,
  output logic                      busy
);
  import tcrr_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (stat.clear_last) begin
          state_next = stat.clear_reply ? ST_CURSOR : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          unique case (command)
            CMD_WRITE: state_next = ST_ADDR;
            CMD_READ:  state_next = ST_ADDR;
            CMD_CLEAR: state_next = ST_CLEAR;
            CMD_ACK:   state_next = ST_CURSOR;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_ADDR: begin
        state_next = (stat.req_cmd == CMD_READ) ? ST_READ : ST_WRITE;
      end
      ST_WRITE: begin
        state_next = stat.wrap_full ? ST_ZERO_SETUP : ST_CURSOR;
      end
      ST_READ:       state_next = ST_CURSOR;
      ST_ZERO_SETUP: state_next = ST_ZERO;
      ST_ZERO: begin
        if (stat.zero_last) begin
          state_next = ST_CURSOR;
        end
      end
      ST_CURSOR: state_next = ST_RESULT;
      ST_RESULT: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl  = '0;
    busy = 1'b1;
    unique case (state)
      ST_CLEAR:      ctl.clear_step = 1'b1;
      ST_IDLE: begin
        busy       = 1'b0;
        ctl.accept = start;
      end
      ST_ADDR:       ctl.load_addr  = 1'b1;
      ST_WRITE:      ctl.write_cell = 1'b1;
      ST_READ:       ctl.read_cell  = 1'b1;
      ST_ZERO_SETUP: ctl.zero_setup = 1'b1;
      ST_ZERO:       ctl.zero_step  = 1'b1;
      ST_CURSOR:     ctl.calc_vis   = 1'b1;
      ST_RESULT:     ctl.emit       = 1'b1;
      default:       busy           = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/tcrr_datapath.sv
// Datapath with the line store, ring indices, address unit and result register.
`default_nettype none

module tcrr_datapath #(
  parameter int ROWS    = tcrr_pkg::ROWS_DEF,
  parameter int COLUMNS = tcrr_pkg::COLUMNS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire tcrr_pkg::ctl_cmd_t   ctl,
  input  wire tcrr_pkg::request_t   request,
  output tcrr_pkg::ctl_stat_t       stat,
  output tcrr_pkg::result_t         result,
  output logic                      strobe
);
  import tcrr_pkg::*;

  localparam int RING    = ROWS + 1;
  localparam int STORE   = RING * COLUMNS;
  localparam int LINE_W  = $clog2(RING);
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ADDR_W  = $clog2(STORE);
  localparam int SUM_W   = ((LINE_W > 5) ? LINE_W : 5) + 1;
  localparam int CMPC_W  = ((COL_W > 7) ? COL_W : 7) + 1;
  localparam int CUR_W   = ((LINE_W + COL_W + 2) > 12) ? (LINE_W + COL_W + 2) : 12;

  logic [7:0]        mem [STORE];
  logic [7:0]        rdata;

  cmd_code_t         req_cmd;
  logic [7:0]        req_data;
  logic [LINE_W-1:0] rline;
  logic [COL_W-1:0]  rcol;
  logic              read_ok;
  logic [LINE_W-1:0] cur_line;
  logic [COL_W-1:0]  cur_col;
  logic [LINE_W-1:0] oldest;
  logic              redraw;
  logic [ADDR_W-1:0] addr;
  logic [COL_W-1:0]  zcnt;
  logic [LINE_W-1:0] vis;
  logic              clear_reply;

  function automatic logic [LINE_W-1:0] next_line(input logic [LINE_W-1:0] line);
    if (line == LINE_W'(RING - 1)) begin
      return '0;
    end
    return line + LINE_W'(1);
  endfunction

  // Read request mapping: screen row counted from the oldest line.
  logic [SUM_W-1:0]  row_sum;
  logic [SUM_W-1:0]  row_wrapped;
  logic              row_ok;
  logic              col_ok;

  always_comb begin
    row_sum     = SUM_W'(oldest) + SUM_W'(request.screen_row);
    row_wrapped = (row_sum >= SUM_W'(RING)) ? (row_sum - SUM_W'(RING)) : row_sum;
    row_ok      = SUM_W'(request.screen_row) < SUM_W'(RING);
    col_ok      = CMPC_W'(request.screen_col) < CMPC_W'(COLUMNS);
  end

  // Cell address: one multiply by the line length, registered in addr.
  logic [LINE_W-1:0] line_sel;
  logic [COL_W-1:0]  col_sel;
  logic [ADDR_W-1:0] cell_addr;

  always_comb begin
    if (ctl.zero_setup) begin
      line_sel = oldest;
      col_sel  = '0;
    end else if (req_cmd == CMD_READ) begin
      line_sel = rline;
      col_sel  = rcol;
    end else begin
      line_sel = cur_line;
      col_sel  = cur_col;
    end
    cell_addr = ADDR_W'(line_sel) * ADDR_W'(COLUMNS) + ADDR_W'(col_sel);
  end

  logic              is_newline;
  logic              wrap;
  logic [LINE_W-1:0] line_after;
  logic              full;

  always_comb begin
    is_newline = (req_data == NEWLINE_BYTE);
    wrap       = is_newline || (cur_col == COL_W'(COLUMNS - 1));
    line_after = next_line(cur_line);
    full       = (next_line(line_after) == oldest);
  end

  logic [LINE_W:0]   vis_sum;
  logic [CUR_W-1:0]  cursor_full;

  always_comb begin
    if (cur_line >= oldest) begin
      vis_sum = (LINE_W + 1)'(cur_line) - (LINE_W + 1)'(oldest);
    end else begin
      vis_sum = (LINE_W + 1)'(cur_line) + (LINE_W + 1)'(RING) - (LINE_W + 1)'(oldest);
    end
    cursor_full = (CUR_W'(vis) + CUR_W'(1)) * CUR_W'(COLUMNS) + CUR_W'(cur_col);
  end

  always_comb begin
    stat.req_cmd     = req_cmd;
    stat.wrap_full   = wrap && full;
    stat.zero_last   = (zcnt == COL_W'(COLUMNS - 1));
    stat.clear_last  = (addr == ADDR_W'(STORE - 1));
    stat.clear_reply = clear_reply;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_line    <= '0;
      cur_col     <= '0;
      oldest      <= '0;
      redraw      <= 1'b0;
      addr        <= '0;
      clear_reply <= 1'b0;
      strobe      <= 1'b0;
      req_cmd     <= CMD_ACK;
    end else begin
      strobe <= ctl.emit;
      if (ctl.accept) begin
        req_cmd  <= cmd_code_t'(request.command);
        req_data <= request.data_byte;
        read_ok  <= row_ok && col_ok;
        rline    <= (row_ok && col_ok) ? LINE_W'(row_wrapped) : '0;
        rcol     <= (row_ok && col_ok) ? COL_W'(request.screen_col) : '0;
        if (cmd_code_t'(request.command) == CMD_CLEAR) begin
          cur_line    <= '0;
          cur_col     <= '0;
          oldest      <= '0;
          redraw      <= 1'b0;
          addr        <= '0;
          clear_reply <= 1'b1;
        end
        if (cmd_code_t'(request.command) == CMD_ACK) begin
          redraw <= 1'b0;
        end
      end
      if (ctl.load_addr || ctl.zero_setup) begin
        addr <= cell_addr;
      end
      if (ctl.zero_setup) begin
        zcnt <= '0;
      end
      if (ctl.write_cell) begin
        if (wrap) begin
          cur_col  <= '0;
          cur_line <= line_after;
          redraw   <= 1'b1;
        end else begin
          cur_col <= cur_col + COL_W'(1);
        end
      end
      if (ctl.zero_step) begin
        addr <= addr + ADDR_W'(1);
        zcnt <= zcnt + COL_W'(1);
        if (stat.zero_last) begin
          oldest <= next_line(oldest);
        end
      end
      if (ctl.clear_step) begin
        addr <= addr + ADDR_W'(1);
      end
      if (ctl.calc_vis) begin
        vis <= LINE_W'(vis_sum);
      end
      if (ctl.emit) begin
        result.cell_char     <= (req_cmd == CMD_READ && read_ok) ? rdata : 8'd0;
        result.cursor_offset <= cursor_full[11:0];
        result.redraw_needed <= redraw;
        clear_reply          <= 1'b0;
      end
    end
  end

  // Line store: one port, written by byte writes, line zeroing and the clear pass.
  logic       mem_we;
  logic [7:0] mem_wd;

  always_comb begin
    mem_we = (ctl.write_cell && !is_newline) || ctl.zero_step || ctl.clear_step;
    mem_wd = ctl.write_cell ? req_data : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= mem_wd;
    end
    if (ctl.read_cell) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/text_console_row_ring.sv
// Top level of the text console row ring: controller plus datapath.
// Sequence: a write or newline beat passes ADDR, WRITE, CURSOR and RESULT, a read ADDR, READ,
// CURSOR and RESULT, an acknowledge CURSOR and RESULT; a wrap into a full ring zeroes the oldest
// line after WRITE, and a clear sweeps the store first; strobe is registered from RESULT.
// Throughput: one beat per busy period; the next beat can be taken as the result shows.
// Reset (rst, synchronous) runs a clearing pass over all (ROWS+1)*COLUMNS cells, busy high, no stall.
`default_nettype none

module text_console_row_ring #(
  parameter int ROWS    = tcrr_pkg::ROWS_DEF,
  parameter int COLUMNS = tcrr_pkg::COLUMNS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire tcrr_pkg::request_t  request,
  output tcrr_pkg::result_t        result,
  output logic                     strobe
);
  import tcrr_pkg::*;

  // The controller walks each accepted beat through a short sequence of
  // states; the datapath owns all storage and arithmetic. They talk through
  // the command and status structs below; the command code also comes from the port.
  ctl_cmd_t  ctl;
  ctl_stat_t stat;

  // The command code is decoded straight from the request port while idle,
  // so the first working state can be chosen at the accepting edge.
  tcrr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (cmd_code_t'(request.command)),
    .stat    (stat),
    .ctl     (ctl),
    .busy    (busy)
  );

  // The datapath holds the (ROWS+1)*COLUMNS byte store, the cursor and
  // oldest-line indices, the redraw flag and the registered result beat.
  tcrr_datapath #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .request (request),
    .stat    (stat),
    .result  (result),
    .strobe  (strobe)
  );

endmodule

`default_nettype wire

FILE: rtl/tcrr_checker.sv
// Port-level checker for the text console row ring and its bind statement.
`default_nettype none

module tcrr_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                strobe
);

  // Reset always starts the store clearing pass.
  a_reset_clears: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low after reset");

  // An accepted beat occupies the block and never answers in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !strobe))
    else $error("accepted beat did not hold busy");

  // One result per beat: strobes never come back to back.
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe)
    else $error("result strobe longer than one cycle");

  // A result only follows a busy period.
  a_strobe_after_work: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result strobe without preceding work");

endmodule

bind text_console_row_ring tcrr_checker u_tcrr_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .strobe  (strobe)
);

`default_nettype wire
